### sv/fqss_pkg.sv
`default_nettype none
package fqss_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CmdW = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CmdEnq = 2'd0,
    CmdDeq = 2'd1,
    CmdSum = 2'd2,
    CmdHas = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SDeqWait,
    SScan,
    SDone
  } state_e;

endpackage
`default_nettype wire

### sv/fqss_if.sv
`default_nettype none
interface fqss_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [fqss_pkg::CmdW-1:0]     command;
  logic signed [fqss_pkg::ValueW-1:0]   value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface fqss_out_if #(
  parameter int unsigned CNT_W = $clog2(fqss_pkg::DefaultDepth + 1)
);
  logic                                 valid;
  logic                                 ready;
  logic        [fqss_pkg::StatusW-1:0]  status;
  logic signed [fqss_pkg::ValueW-1:0]   total;
  logic                                 found;
  logic        [CNT_W-1:0]              occupancy;

  modport source (output valid, output status, output total, output found,
                  output occupancy, input ready);
  modport sink (input valid, input status, input total, input found,
                input occupancy, output ready);
endinterface
`default_nettype wire

### sv/fifo_queue_sum_search_top.sv
`default_nettype none
// Bounded FIFO of DEPTH signed 32-bit words with a running wrapping sum and a
// membership search; every input transfer yields exactly one result transfer.
// Entries live in a single-port-write, registered-read ring memory. One item
// is worked at a time: enqueue, sum query and refused commands go straight
// to the result state, dequeue first waits on one memory read of the head,
// and a membership query on a non-empty queue reads one entry per cycle from
// the head and stops at the first hit or after the last held entry.
// The result sits in an output register, so the next item is taken while it
// waits for the sink.
module fifo_queue_sum_search_top #(
  parameter int unsigned DEPTH = fqss_pkg::DefaultDepth,
  localparam int unsigned IdxW = $clog2(DEPTH)
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  fqss_in_if.sink      in_i,
  fqss_out_if.source   out_o
);

  logic                          ram_we, ram_re;
  logic [IdxW-1:0]               ram_waddr, ram_raddr;
  logic [fqss_pkg::ValueW-1:0]   ram_wdata, ram_rdata;

  fqss_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  fqss_ram #(.DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire

### sv/fqss_ram.sv
`default_nettype none
module fqss_ram #(
  parameter int unsigned DEPTH = fqss_pkg::DefaultDepth,
  localparam int unsigned IdxW = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [IdxW-1:0]               waddr_i,
  input  wire logic [fqss_pkg::ValueW-1:0]   wdata_i,
  input  wire logic                          re_i,
  input  wire logic [IdxW-1:0]               raddr_i,
  output      logic [fqss_pkg::ValueW-1:0]   rdata_o
);

  logic [fqss_pkg::ValueW-1:0] mem [DEPTH];
  logic [fqss_pkg::ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### sv/fqss_ctrl.sv
`default_nettype none
module fqss_ctrl #(
  parameter int unsigned DEPTH = fqss_pkg::DefaultDepth,
  localparam int unsigned IdxW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  fqss_in_if.sink                            in_i,
  fqss_out_if.source                         out_o,
  output      logic                          ram_we_o,
  output      logic [IdxW-1:0]               ram_waddr_o,
  output      logic [fqss_pkg::ValueW-1:0]   ram_wdata_o,
  output      logic                          ram_re_o,
  output      logic [IdxW-1:0]               ram_raddr_o,
  input  wire logic [fqss_pkg::ValueW-1:0]   ram_rdata_i
);

  fqss_pkg::state_e              state_q, state_d;
  logic [IdxW-1:0]               head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CntW-1:0]               cnt_q, cnt_d, rem_q, rem_d;
  logic [fqss_pkg::ValueW-1:0]   sum_q, sum_d, key_q, key_d;
  fqss_pkg::status_e             st_q, st_d;
  logic                          found_q, found_d;
  logic                          out_valid_q, out_valid_d;
  logic [fqss_pkg::StatusW-1:0]  out_status_q;
  logic [fqss_pkg::ValueW-1:0]   out_total_q;
  logic                          out_found_q;
  logic [CntW-1:0]               out_occ_q;

  logic              acc, full, empty, hit, last, out_free, out_load;
  fqss_pkg::cmd_e    cmd;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i);
    nxt = (i == IdxW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign in_i.ready = (state_q == fqss_pkg::SIdle);
  assign acc        = in_i.valid && in_i.ready;
  assign cmd        = fqss_pkg::cmd_e'(in_i.command);
  assign full       = (cnt_q == CntW'(DEPTH));
  assign empty      = (cnt_q == '0);
  assign hit        = (ram_rdata_i == key_q);
  assign last       = (rem_q == CntW'(1));
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == fqss_pkg::SDone) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fqss_pkg::SIdle: begin
        if (acc) begin
          unique case (cmd)
            fqss_pkg::CmdDeq: state_d = empty ? fqss_pkg::SDone : fqss_pkg::SDeqWait;
            fqss_pkg::CmdHas: state_d = empty ? fqss_pkg::SDone : fqss_pkg::SScan;
            default:          state_d = fqss_pkg::SDone;
          endcase
        end
      end
      fqss_pkg::SDeqWait: state_d = fqss_pkg::SDone;
      fqss_pkg::SScan: begin
        if (hit || last) begin
          state_d = fqss_pkg::SDone;
        end
      end
      fqss_pkg::SDone: begin
        if (out_free) begin
          state_d = fqss_pkg::SIdle;
        end
      end
      default: state_d = fqss_pkg::SIdle;
    endcase
  end

  // datapath and memory access
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    sum_d       = sum_q;
    key_d       = key_q;
    st_d        = st_q;
    found_d     = found_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = tail_q;
    ram_wdata_o = in_i.value;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q;
    unique case (state_q)
      fqss_pkg::SIdle: begin
        if (acc) begin
          key_d   = in_i.value;
          found_d = 1'b0;
          st_d    = fqss_pkg::StatOk;
          unique case (cmd)
            fqss_pkg::CmdEnq: begin
              if (full) begin
                st_d = fqss_pkg::StatFull;
              end else begin
                ram_we_o = 1'b1;
                tail_d   = nxt(tail_q);
                cnt_d    = cnt_q + 1'b1;
                sum_d    = sum_q + in_i.value;
              end
            end
            fqss_pkg::CmdDeq: begin
              if (empty) begin
                st_d = fqss_pkg::StatEmpty;
              end else begin
                ram_re_o = 1'b1;
              end
            end
            fqss_pkg::CmdHas: begin
              if (!empty) begin
                ram_re_o = 1'b1;
                ptr_d    = nxt(head_q);
                rem_d    = cnt_q;
              end
            end
            default: ;
          endcase
        end
      end
      fqss_pkg::SDeqWait: begin
        sum_d  = sum_q - ram_rdata_i;
        head_d = nxt(head_q);
        cnt_d  = cnt_q - 1'b1;
      end
      fqss_pkg::SScan: begin
        if (hit) begin
          found_d = 1'b1;
        end else if (!last) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q;
          ptr_d       = nxt(ptr_q);
          rem_d       = rem_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fqss_pkg::SIdle;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    key_q   <= key_d;
    st_q    <= st_d;
    found_q <= found_d;
    if (out_load) begin
      out_status_q <= st_q;
      out_total_q  <= sum_q;
      out_found_q  <= found_q;
      out_occ_q    <= cnt_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.total     = out_total_q;
  assign out_o.found     = out_found_q;
  assign out_o.occupancy = out_occ_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(DEPTH)) |-> head_q == tail_q)
    else $error("head and tail disagree with count");

  a_enq_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd == fqss_pkg::CmdEnq && !full) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("enqueue did not add an entry");

  a_scan_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fqss_pkg::SScan) |-> rem_q != '0)
    else $error("scan with nothing left to read");

endmodule
`default_nettype wire

### bench/fifo_queue_sum_search_top_tb.sv
`timescale 1ns / 1ps

module fifo_queue_sum_search_top_tb;

  localparam int unsigned DEPTH = fqss_pkg::DefaultDepth;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    fqss_pkg::status_e status;
    logic [31:0]       total;
    logic              found;
    logic [4:0]        occupancy;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  fqss_in_if  in_if ();
  fqss_out_if out_if ();

  fifo_queue_sum_search_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // queue model state
  logic [31:0] ring_words [DEPTH];
  int          head_slot;
  int          tail_slot;
  int          held_count;
  logic [31:0] held_sum;

  outcome_t outcome_q[$];
  int       mismatches;
  int       idle_cycles;
  int       send_idle;
  int       recv_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit holds(logic [31:0] word);
    for (int n = 0; n < held_count; n++) begin
      if (ring_words[(head_slot + n) % DEPTH] == word) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t queue_outcome(fqss_pkg::cmd_e cmd, logic [31:0] word);
    outcome_t res;
    res.status = fqss_pkg::StatOk;
    res.found = 1'b0;
    case (cmd)
      fqss_pkg::CmdEnq: begin
        if (held_count >= DEPTH) begin
          res.status = fqss_pkg::StatFull;
        end else begin
          ring_words[tail_slot] = word;
          tail_slot = (tail_slot + 1) % DEPTH;
          held_count++;
          held_sum += word;
        end
      end
      fqss_pkg::CmdDeq: begin
        if (held_count == 0) begin
          res.status = fqss_pkg::StatEmpty;
        end else begin
          held_sum -= ring_words[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          held_count--;
        end
      end
      fqss_pkg::CmdHas: res.found = holds(word);
      default: ;
    endcase
    res.total = held_sum;
    res.occupancy = 5'(held_count);
    return res;
  endfunction

  function automatic logic [31:0] any_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) begin
      case ($urandom_range(4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end else if (roll < 45) begin
      return 32'($signed($urandom_range(16)) - 8);
    end
    return $urandom;
  endfunction

  task automatic send_item(fqss_pkg::cmd_e cmd, logic [31:0] word);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.command = cmd;
    in_if.value = word;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    outcome_q.push_back(queue_outcome(cmd, word));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_queue();
    send_item(fqss_pkg::CmdDeq, $urandom);
    send_item(fqss_pkg::CmdSum, $urandom);
    send_item(fqss_pkg::CmdHas, 32'h0000_0000);
    send_item(fqss_pkg::CmdEnq, 32'hFFFF_FFFB);
    send_item(fqss_pkg::CmdDeq, $urandom);
  endtask

  task automatic test_full_queue();
    logic [31:0] word;
    send_item(fqss_pkg::CmdEnq, 32'h7FFF_FFFF);
    send_item(fqss_pkg::CmdEnq, 32'h7FFF_FFFF);
    send_item(fqss_pkg::CmdEnq, 32'h8000_0000);
    send_item(fqss_pkg::CmdEnq, 32'hFFFF_FFFF);
    send_item(fqss_pkg::CmdEnq, 32'h0000_0000);
    send_item(fqss_pkg::CmdEnq, 32'h0000_0001);
    for (int n = 6; n < DEPTH; n++) begin
      word = $urandom;
      send_item(fqss_pkg::CmdEnq, word);
    end
    send_item(fqss_pkg::CmdEnq, $urandom);
    send_item(fqss_pkg::CmdHas, word);
    do word = $urandom; while (holds(word));
    send_item(fqss_pkg::CmdHas, word);
    send_item(fqss_pkg::CmdSum, $urandom);
  endtask

  task automatic run_traffic(int count, int sender_pct, int receiver_pct);
    int mode;
    int roll;
    int enq_lim;
    int deq_lim;
    fqss_pkg::cmd_e cmd;
    logic [31:0] word;
    send_idle = sender_pct;
    recv_idle = receiver_pct;
    mode = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) mode = $urandom_range(2);
      case (mode)
        0: begin
          enq_lim = 65;
          deq_lim = 80;
        end
        1: begin
          enq_lim = 20;
          deq_lim = 75;
        end
        default: begin
          enq_lim = 40;
          deq_lim = 75;
        end
      endcase
      roll = $urandom_range(99);
      if (roll < enq_lim) cmd = fqss_pkg::CmdEnq;
      else if (roll < deq_lim) cmd = fqss_pkg::CmdDeq;
      else if (roll < deq_lim + 10) cmd = fqss_pkg::CmdSum;
      else cmd = fqss_pkg::CmdHas;
      if (cmd == fqss_pkg::CmdHas && held_count > 0 && $urandom_range(1) == 1) begin
        word = ring_words[(head_slot + $urandom_range(held_count - 1)) % DEPTH];
      end else begin
        word = any_word();
      end
      send_item(cmd, word);
    end
    drain_results();
  endtask

  task automatic test_receiver_stalls();
    run_traffic(150, 15, 84);
  endtask

  task automatic test_sender_gaps();
    run_traffic(150, 84, 15);
  endtask

  task automatic test_back_to_back();
    run_traffic(150, 0, 0);
  endtask

  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin : check_result
    outcome_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d total %0d found %0d occupancy %0d",
                   out_if.status, $signed(out_if.total), out_if.found, out_if.occupancy);
        end
      end else begin
        want = outcome_q.pop_front();
        if (out_if.status !== want.status || out_if.total !== want.total ||
            out_if.found !== want.found || out_if.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected status %0d total %0d found %0d occupancy %0d",
                     want.status, $signed(want.total), want.found, want.occupancy);
            $display("  actual status %0d total %0d found %0d occupancy %0d",
                     out_if.status, $signed(out_if.total), out_if.found, out_if.occupancy);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = fqss_pkg::CmdEnq;
    in_if.value = '0;
    out_if.ready = 1'b0;
    send_idle = 15;
    recv_idle = 84;
    mismatches = 0;
    idle_cycles = 0;
    head_slot = 0;
    tail_slot = 0;
    held_count = 0;
    held_sum = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_full_queue();
    drain_results();
    test_receiver_stalls();
    test_sender_gaps();
    test_back_to_back();

    repeat (4 * DEPTH) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
